### hw/rtl/assert_macros.svh
// assertion macros shared by the tokenizer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define STT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("tokenizer assertion failed");
// condition must never be true outside reset
`define STT_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tokenizer forbidden condition seen");
`else
`define STT_ASSERT(name, clk, rst_n, prop)
`define STT_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

### hw/rtl/stt_pkg.sv
// types, constants and byte classes for the source text tokenizer
package stt_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_USCORE = 8'h5f;

	// result queue depth, must hold two results plus slack
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_IDENT  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_STRING = 2'd0,
		KIND_NUMBER = 2'd1,
		KIND_IDENT  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  tbyte;
		logic        has;
		logic        first;
		logic        last;
		logic        drop;
		logic        run_last;
	} res_t;

	// results of one item, up to two
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} lex_out_t;

	function automatic logic is_digit(logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
	endfunction

	function automatic logic is_ident_start(logic [7:0] b);
		return is_alpha(b) || (b == CH_USCORE);
	endfunction

	function automatic logic is_ident_cont(logic [7:0] b);
		return is_ident_start(b) || is_digit(b);
	endfunction

	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic has, logic first,
			logic last, logic drop);
		res_t r;
		r.kind     = k;
		r.tbyte    = b;
		r.has      = has;
		r.first    = first;
		r.last     = last;
		r.drop     = drop;
		r.run_last = 1'b0;
		return r;
	endfunction

endpackage

### hw/rtl/stt_lexer.sv
// lexer state registers and per-byte decode into up to two results
`include "assert_macros.svh"

module stt_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output stt_pkg::lex_out_t lex_out
);
	import stt_pkg::*;

	mode_t    mode_q, mode_d;
	logic     dot_q, dot_d;
	logic     str_has_q, str_has_d;
	logic     scan;
	logic     st_en;
	res_t     st;
	lex_out_t lo;

	// decode one byte against the current mode
	always_comb begin
		mode_d    = mode_q;
		dot_d     = dot_q;
		str_has_d = str_has_q;
		lo        = '0;
		scan      = 1'b0;
		st        = '0;
		st_en     = 1'b0;
		if (end_of_text) begin
			case (mode_q)
				MODE_NUMBER: begin
					lo.r0  = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
					lo.cnt = 2'd1;
				end
				MODE_IDENT: begin
					lo.r0  = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
					lo.cnt = 2'd1;
				end
				MODE_STRING: begin
					lo.r0  = mk_res(KIND_STRING, 8'h00, 1'b0, ~str_has_q, 1'b1, 1'b1);
					lo.cnt = 2'd1;
				end
				default: ;
			endcase
			mode_d    = MODE_IDLE;
			dot_d     = 1'b0;
			str_has_d = 1'b0;
		end else if (mode_q == MODE_STRING) begin
			if (text_byte == CH_QUOTE) begin
				lo.r0     = mk_res(KIND_STRING, 8'h00, 1'b0, ~str_has_q, 1'b1, 1'b0);
				mode_d    = MODE_IDLE;
				str_has_d = 1'b0;
			end else begin
				lo.r0     = mk_res(KIND_STRING, text_byte, 1'b1, ~str_has_q, 1'b0, 1'b0);
				str_has_d = 1'b1;
			end
			lo.cnt = 2'd1;
		end else begin
			scan = 1'b1;
			// continue or close an open number or identifier
			if (mode_q == MODE_NUMBER) begin
				lo.cnt = 2'd1;
				if (is_digit(text_byte) || (text_byte == CH_DOT)) begin
					lo.r0 = mk_res(KIND_NUMBER, text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
					scan  = 1'b0;
				end else begin
					lo.r0  = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
					mode_d = MODE_IDLE;
				end
			end else if (mode_q == MODE_IDENT) begin
				lo.cnt = 2'd1;
				if (is_ident_cont(text_byte)) begin
					lo.r0 = mk_res(KIND_IDENT, text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
					scan  = 1'b0;
				end else begin
					lo.r0  = mk_res(KIND_IDENT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
					mode_d = MODE_IDLE;
				end
			end
			// examine the byte as a token start
			if (scan) begin
				dot_d = 1'b0;
				if (dot_q && is_digit(text_byte)) begin
					lo.r0  = mk_res(KIND_NUMBER, CH_DOT, 1'b1, 1'b1, 1'b0, 1'b0);
					lo.r1  = mk_res(KIND_NUMBER, text_byte, 1'b1, 1'b0, 1'b0, 1'b0);
					lo.cnt = 2'd2;
					mode_d = MODE_NUMBER;
				end else if (text_byte == CH_QUOTE) begin
					mode_d    = MODE_STRING;
					str_has_d = 1'b0;
				end else if (is_digit(text_byte) || (text_byte == CH_MINUS)) begin
					st     = mk_res(KIND_NUMBER, text_byte, 1'b1, 1'b1, 1'b0, 1'b0);
					st_en  = 1'b1;
					mode_d = MODE_NUMBER;
				end else if (text_byte == CH_DOT) begin
					dot_d = 1'b1;
				end else if (is_ident_start(text_byte)) begin
					st     = mk_res(KIND_IDENT, text_byte, 1'b1, 1'b1, 1'b0, 1'b0);
					st_en  = 1'b1;
					mode_d = MODE_IDENT;
				end
			end
		end
		// token start goes into the next free slot
		if (st_en) begin
			if (lo.cnt == 2'd0) begin
				lo.r0 = st;
			end else begin
				lo.r1 = st;
			end
			lo.cnt = lo.cnt + 2'd1;
		end
		// mark the last result of this byte
		case (lo.cnt)
			2'd1: lo.r0.run_last = 1'b1;
			2'd2: lo.r1.run_last = 1'b1;
			default: ;
		endcase
	end

	assign lex_out = lo;

	// state advances when the byte is handed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			dot_q     <= 1'b0;
			str_has_q <= 1'b0;
		end else if (adv) begin
			mode_q    <= mode_d;
			dot_q     <= dot_d;
			str_has_q <= str_has_d;
		end
	end

	`STT_ASSERT(a_dot_only_idle, clk, arst_n, dot_q |-> (mode_q == MODE_IDLE))
	`STT_ASSERT(a_content_only_string, clk, arst_n, str_has_q |-> (mode_q == MODE_STRING))

endmodule

### hw/rtl/stt_queue.sv
// result queue: takes up to two results a cycle while it has room, gives one beat a cycle while out_ready is high
`include "assert_macros.svh"

module stt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  stt_pkg::lex_out_t lex_out,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output stt_pkg::res_t     out_res
);
	import stt_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic [1:0]        push_cnt;
	logic              pop;

	assign push_cnt  = push ? lex_out.cnt : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_q];
	// space for a worst-case item regardless of this cycle's pop
	assign room      = (count_q <= QCNT_W'(QDEPTH - 2));

	// storage writes
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= lex_out.r0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= lex_out.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push_cnt);
			rd_q    <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	`STT_ASSERT_NEVER(a_no_overflow, clk, arst_n, QCNT_W'(push_cnt) > (QCNT_W'(QDEPTH) - count_q))
	`STT_ASSERT(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QDEPTH))

endmodule

### hw/rtl/source_text_tokenizer.sv
// top level of the source text tokenizer
// Streaming tokenizer: one source byte per input beat, one token result per output
// beat. A byte goes into an input register, is decoded there against the lexer
// state and its results (none, one or two) go into a four-entry result queue.
// A new byte is taken every cycle as long as the queue has room for two more
// results, so the input rate is one byte per cycle while bytes give at most one
// result each and the output is not stalled; a byte that closes a token and opens
// another gives two results, the output port carrying one result per cycle while
// out_ready is high. A byte is held in the input register and its results in the
// queue storage on their way to the output. No clearing pass is needed after reset.
module source_text_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] token_kind,
	output logic [7:0] token_byte,
	output logic       has_byte,
	output logic       token_first,
	output logic       token_last,
	output logic       token_drop,
	output logic       run_last
);
	import stt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic       room;
	logic       adv;
	lex_out_t   lex_out;
	res_t       out_res;

	assign adv      = valid_s1 && room;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	stt_lexer u_lexer (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.text_byte   (byte_s1),
		.end_of_text (eot_s1),
		.lex_out     (lex_out)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv),
		.lex_out   (lex_out),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	// result fields
	assign token_kind  = out_res.kind;
	assign token_byte  = out_res.has ? out_res.tbyte : 8'h00;
	assign has_byte    = out_res.has;
	assign token_first = out_res.first;
	assign token_last  = out_res.last;
	assign token_drop  = out_res.drop;
	assign run_last    = out_res.run_last;

endmodule
